[design/fadd_pkg.sv]
// Shared types and constants for the fraction add-and-reduce block.
// Used by the top, GCD and divider modules in this folder; depends on nothing else.
package fadd_pkg;

  // Widths of the sum numerator, the denominator and their magnitudes.
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int MAG_W = 32;
  localparam int SH_W  = 5;

  // One input beat: two fractions a/b and c/d.
  typedef struct packed {
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
  } in_t;

  // One result beat: the reduced sum.
  typedef struct packed {
    logic signed [NUM_W-1:0] sum_num;
    logic signed [DEN_W-1:0] sum_den;
  } out_t;

  // Status that an iterative unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[design/fraction_add_reduce_top.sv]
// Fraction add-and-reduce top level: sequencer around the multiplier,
// GCD and divider units. Depends on fadd_pkg, fadd_mul, fadd_gcd, fadd_div.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one beat holding
//   two signed fractions a/b and c/d. The result channel (out_valid,
//   out_stall, out_data) returns one beat with (a*d + c*b)/(b*d) reduced by
//   the GCD of the magnitudes; each part keeps its sign.
//   One item is worked at a time; in_stall is high while it is in progress.
//   Steps: products and sum through the single multiplier (S_MUL0, S_MUL1,
//   S_MUL2, S_SUM), then the binary GCD unit (one shift or subtract a
//   cycle), then, when the divisor exceeds one, two passes of the
//   bit-serial divider, one over the numerator and one over the
//   denominator. The GCD loop sets most of the spread in item time.
//   The result sits in an output register, so the next item is accepted
//   while a result still waits; if the receiver stalls, a finished second
//   result holds inside until the register frees.
//   Synchronous reset (rst_n low) returns the sequencer to idle and drops
//   any pending result.
module fraction_add_reduce_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fadd_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fadd_pkg::out_t   out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_DIVN = 4'd6;
  localparam logic [3:0] S_DIVD = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  fadd_pkg::in_t                 item_r, item_nxt;
  logic [31:0]                   ad_r, ad_nxt;
  logic [fadd_pkg::NUM_W-1:0]    num_r, num_nxt, res_num_r, res_num_nxt;
  logic [fadd_pkg::DEN_W-1:0]    den_r, den_nxt, res_den_r, res_den_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fadd_pkg::out_t                out_data_r, out_data_nxt;

  logic signed [15:0]            mul_a, mul_b;
  logic signed [31:0]            prod;
  logic [fadd_pkg::NUM_W-1:0]    num_neg, q_num_ext, q_num_neg;
  logic [fadd_pkg::DEN_W-1:0]    den_neg, den_src, q_den_neg;
  logic [fadd_pkg::MAG_W-1:0]    num_mag, den_mag, den_src_mag;
  logic [fadd_pkg::MAG_W-1:0]    gcd_val, quo;
  fadd_pkg::unit_stat_t          gcd_stat, div_stat;
  logic                          gcd_start, div_start, g_big, in_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      S_MUL0: begin
        mul_a = item_r.num_a;
        mul_b = item_r.den_b;
      end
      S_MUL1: begin
        mul_a = item_r.num_b;
        mul_b = item_r.den_a;
      end
      default: begin
        mul_a = item_r.den_a;
        mul_b = item_r.den_b;
      end
    endcase
  end

  fadd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Magnitudes of the unreduced sum; the denominator comes straight off
  // the multiplier while the GCD is started.
  assign num_neg     = -num_r;
  assign num_mag     = num_r[fadd_pkg::NUM_W-1] ? num_neg[fadd_pkg::MAG_W-1:0]
                                                : num_r[fadd_pkg::MAG_W-1:0];
  assign den_src     = (state_r == S_SUM) ? prod : den_r;
  assign den_neg     = -den_src;
  assign den_src_mag = den_src[fadd_pkg::DEN_W-1] ? den_neg : den_src;
  assign den_mag     = den_src_mag;

  assign gcd_start = state_r == S_SUM;

  fadd_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .x     (num_mag),
    .y     (den_mag),
    .stat  (gcd_stat),
    .g     (gcd_val)
  );

  // Reduction only when the divisor exceeds one.
  assign g_big     = gcd_val[fadd_pkg::MAG_W-1:1] != '0;
  assign div_start = (state_r == S_GCD && gcd_stat.done && g_big) ||
                     (state_r == S_DIVN && div_stat.done);

  fadd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ((state_r == S_GCD) ? num_mag : den_mag),
    .divisor  (gcd_val),
    .stat     (div_stat),
    .quo      (quo)
  );

  // Restore signs on the quotients.
  assign q_num_ext = {1'b0, quo};
  assign q_num_neg = -q_num_ext;
  assign q_den_neg = -quo;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ad_nxt        = ad_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt  = in_data;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: begin
        ad_nxt    = prod;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        num_nxt   = {ad_r[31], ad_r} + {prod[31], prod};
        state_nxt = S_SUM;
      end
      S_SUM: begin
        den_nxt   = prod;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (gcd_stat.done) begin
          if (g_big) begin
            state_nxt = S_DIVN;
          end else begin
            res_num_nxt = num_r;
            res_den_nxt = den_r;
            state_nxt   = S_DONE;
          end
        end
      end
      S_DIVN: begin
        if (div_stat.done) begin
          res_num_nxt = num_r[fadd_pkg::NUM_W-1] ? q_num_neg : q_num_ext;
          state_nxt   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_stat.done) begin
          res_den_nxt = den_r[fadd_pkg::DEN_W-1] ? q_den_neg : quo;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.sum_num = res_num_r;
          out_data_nxt.sum_den = res_den_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ad_r       <= ad_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    res_num_r  <= res_num_nxt;
    res_den_r  <= res_den_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result beat appears only when the sequencer leaves the done state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");

  // The GCD unit reports completion only while the sequencer waits for it.
  a_gcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_stat.done |-> state_r == S_GCD)
    else $error("GCD completion outside the GCD wait state");

  // The GCD unit is busy only while the sequencer waits for it.
  a_gcd_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_stat.busy |-> state_r == S_GCD)
    else $error("GCD unit busy outside the GCD wait state");

  // The divider reports completion only during one of the two divide passes.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIVN || state_r == S_DIVD))
    else $error("divider completion outside a divide pass");

  // A divisor above one always leads to the numerator divide pass.
  a_gcd_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD && gcd_stat.done && g_big) |=> state_r == S_DIVN && div_stat.busy)
    else $error("reduction skipped for a divisor above one");

endmodule

[design/fadd_mul.sv]
// Registered 16x16 signed multiplier, reused for all three products.
// Does not depend on fadd_pkg; uses no package items.
module fadd_mul (
  input  logic               clk,
  input  logic signed [15:0] op_a,
  input  logic signed [15:0] op_b,
  output logic signed [31:0] prod_r
);

  logic signed [31:0] prod_nxt;

  // One product per cycle, registered before any further use.
  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[design/fadd_gcd.sv]
// Binary GCD unit over 32-bit magnitudes: one shift or one subtract a cycle.
// Depends on fadd_pkg for widths and the unit status struct.
module fadd_gcd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fadd_pkg::MAG_W-1:0]   x,
  input  logic [fadd_pkg::MAG_W-1:0]   y,
  output fadd_pkg::unit_stat_t         stat,
  output logic [fadd_pkg::MAG_W-1:0]   g
);

  logic [fadd_pkg::MAG_W-1:0] u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [fadd_pkg::SH_W-1:0]  k_r, k_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic                       even_r, even_nxt;
  logic                       u_gt_v;
  logic [fadd_pkg::MAG_W-1:0] sub_a, sub_b, diff;

  // The one shared subtractor: larger minus smaller.
  assign u_gt_v = u_r > v_r;
  assign sub_a  = u_gt_v ? u_r : v_r;
  assign sub_b  = u_gt_v ? v_r : u_r;
  assign diff   = sub_a - sub_b;

  // Step sequencing: a zero operand gives the other at once; else strip common twos first, then reduce until equal.
  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    busy_nxt = busy_r;
    even_nxt = even_r;
    done_nxt = 1'b0;
    if (start) begin
      if (x == '0) begin
        g_nxt    = y;
        done_nxt = 1'b1;
      end else if (y == '0) begin
        g_nxt    = x;
        done_nxt = 1'b1;
      end else begin
        u_nxt    = x;
        v_nxt    = y;
        k_nxt    = '0;
        busy_nxt = 1'b1;
        even_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (even_r) begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          even_nxt = 1'b0;
        end
      end else if (u_r == v_r) begin
        g_nxt    = u_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_gt_v) begin
        u_nxt = diff;
      end else begin
        v_nxt = diff;
      end
    end
  end

  // Control state is reset; operands and result are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      even_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      even_r <= even_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign g         = g_r;

endmodule

[design/fadd_div.sv]
// Restoring unsigned divider, one quotient bit a cycle over the 32-bit dividend.
// Depends on fadd_pkg for widths and the unit status struct.
module fadd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fadd_pkg::MAG_W-1:0]   dividend,
  input  logic [fadd_pkg::MAG_W-1:0]   divisor,
  output fadd_pkg::unit_stat_t         stat,
  output logic [fadd_pkg::MAG_W-1:0]   quo
);

  logic [fadd_pkg::MAG_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [fadd_pkg::SH_W-1:0]  cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic [fadd_pkg::MAG_W:0]   rem_sh, trial;
  logic                       fits;

  // Shift the next dividend bit in and try one subtraction.
  assign rem_sh = {rem_r, quo_r[fadd_pkg::MAG_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[fadd_pkg::MAG_W-1:0] : rem_sh[fadd_pkg::MAG_W-1:0];
      quo_nxt = {quo_r[fadd_pkg::MAG_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for fraction_add_reduce_top: predicts each reduced sum
// and checks every result beat against it. Depends on fadd_pkg and the RTL.
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;

  // Scoreboard: predicts the reduced sum of each accepted beat and checks
  // result beats against the oldest prediction.
  class fraction_sum_board;
    fadd_pkg::out_t pending_sums[$];
    int             mismatches;

    // Sum a/b + c/d and divide both parts by the GCD of their magnitudes.
    function fadd_pkg::out_t reduced_sum(fadd_pkg::in_t item);
      longint          num, den;
      longint unsigned x, y, r;
      fadd_pkg::out_t  sum;
      num = longint'(item.num_a) * longint'(item.den_b)
          + longint'(item.num_b) * longint'(item.den_a);
      den = longint'(item.den_a) * longint'(item.den_b);
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      // A divisor of zero or one leaves the sum untouched.
      if (x > 1) begin
        num = num / longint'(x);
        den = den / longint'(x);
      end
      sum.sum_num = num[fadd_pkg::NUM_W-1:0];
      sum.sum_den = den[fadd_pkg::DEN_W-1:0];
      return sum;
    endfunction

    function void note_input(fadd_pkg::in_t item);
      pending_sums.push_back(reduced_sum(item));
    endfunction

    function void check_result(fadd_pkg::out_t got);
      fadd_pkg::out_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: result beat with nothing expected: %0d/%0d",
                 $time, got.sum_num, got.sum_den);
        mismatches++;
        return;
      end
      want = pending_sums.pop_front();
      if (got.sum_num !== want.sum_num) begin
        $display("%0t: sum_num mismatch: expected %0d, actual %0d",
                 $time, want.sum_num, got.sum_num);
        mismatches++;
      end
      if (got.sum_den !== want.sum_den) begin
        $display("%0t: sum_den mismatch: expected %0d, actual %0d",
                 $time, want.sum_den, got.sum_den);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_sums.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  fadd_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  fadd_pkg::out_t out_data;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;

  fraction_sum_board board;

  fraction_add_reduce_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of 12.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every input beat accepted by the block gets a prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.note_input(in_data);
    end
  end

  // Result side: check accepted beats, then pick the next stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fraction_add_reduce_top regression: fail");
    $finish;
  end

  function automatic fadd_pkg::in_t make_item(int a, int b, int c, int d);
    fadd_pkg::in_t item;
    item.num_a = a[15:0];
    item.den_a = b[15:0];
    item.num_b = c[15:0];
    item.den_b = d[15:0];
    return item;
  endfunction

  // Mix of zeros, extremes, small values that share factors, and full range.
  function automatic logic [15:0] pick_field();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h0000;
      1: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      2, 3, 4: v = 16'($urandom_range(128)) - 16'd64;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic fadd_pkg::in_t random_item();
    fadd_pkg::in_t item;
    item.num_a = pick_field();
    item.den_a = pick_field();
    item.num_b = pick_field();
    item.den_b = pick_field();
    return item;
  endfunction

  // Offer one beat, with random idle cycles first, and hold it until taken.
  task automatic drive_item(fadd_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= fadd_pkg::in_t'({$urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Lower valid and wait until every predicted result has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) drive_item(random_item());
  endtask

  // Main sequence: reset, directed beats, then random phases.
  initial begin
    board = new;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero parts, unit divisor and sign mixes.
    drive_item(make_item(-32768, -32768, -32768, -32768));
    drive_item(make_item(32767, 32767, 32767, 32767));
    drive_item(make_item(32767, -32768, 32767, -32768));
    drive_item(make_item(-32768, 32767, -32768, 32767));
    drive_item(make_item(-32768, 1, -32768, 1));
    drive_item(make_item(32767, -1, 32767, 1));
    drive_item(make_item(0, 5, 0, -7));
    drive_item(make_item(0, -32768, 0, 32767));
    drive_item(make_item(1, 0, 2, 3));
    drive_item(make_item(-3, 0, 2, 5));
    drive_item(make_item(5, 0, 7, 0));
    drive_item(make_item(0, 0, 0, 0));
    drive_item(make_item(0, 0, 9, 4));
    drive_item(make_item(1, 2, 1, 3));
    drive_item(make_item(1, 2, -1, 2));
    drive_item(make_item(3, -4, 5, 6));
    drive_item(make_item(-7, -9, -11, -13));
    drive_item(make_item(6, 8, 10, 12));
    drive_item(make_item(1, 1, -1, 1));
    drive_item(make_item(32767, 32766, -32768, 32765));
    drive_item(make_item(-1, -1, -1, -1));
    drive_item(make_item(16384, -32768, 8192, 16384));

    // Random phases with different idle and stall pressure.
    run_phase(120, 0, 0);
    run_phase(120, 78, 0);
    wait_for_results();
    run_phase(120, 0, 78);
    run_phase(120, 23, 23);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("fraction_add_reduce_top regression: pass");
    end else begin
      $display("fraction_add_reduce_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/fadd_pkg.sv
design/fadd_mul.sv
design/fadd_gcd.sv
design/fadd_div.sv
design/fraction_add_reduce_top.sv
tb/sv/testbench.sv
